>>> hw/rtl/zbdc_pkg.sv
// Shared types and constants for the z-buffer depth compositing block.
// No dependencies; every other file of the block imports this package.
package zbdc_pkg;

    localparam int IDX_W      = 16;
    localparam int IN_DEPTH_W = 24;
    localparam int CH_W       = 8;
    localparam int CH_NUM     = 4;
    localparam int COLOR_W    = CH_W * CH_NUM;

    // Channel placement inside a color store entry
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    localparam logic [CH_W-1:0] CH_MAX     = 8'hFF;
    localparam logic [CH_W-1:0] ROUND_BIAS = 8'h7F;

    typedef struct packed {
        logic [IDX_W-1:0]      pixel_index;
        logic                  first_layer;
        logic [IN_DEPTH_W-1:0] depth;
        logic [CH_W-1:0]       red;
        logic [CH_W-1:0]       green;
        logic [CH_W-1:0]       blue;
        logic [CH_W-1:0]       alpha;
    } t_pix;

endpackage

>>> hw/rtl/zbdc_addr.sv
// Two-stage front end: maps the pixel index to a store position (index modulo PIXELS).
// Depends on zbdc_pkg.
module zbdc_addr #(
    parameter int PIXELS = 65536,
    parameter int ADDR_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  zbdc_pkg::t_pix     i_pix,
    output logic               o_valid,
    input  logic               i_ready,
    output zbdc_pkg::t_pix     o_pix,
    output logic [ADDR_W-1:0]  o_pos
);
    import zbdc_pkg::*;

    localparam bit WRAP = PIXELS < (1 << IDX_W);
    localparam bit POW2 = (PIXELS & (PIXELS - 1)) == 0;

    logic              r_a_valid;
    t_pix              r_a_pix;
    logic              r_b_valid;
    t_pix              r_b_pix;
    logic [ADDR_W-1:0] r_b_pos;
    logic [ADDR_W-1:0] n_b_pos;
    logic              a_free;
    logic              b_free;

    assign b_free  = !r_b_valid || i_ready;
    assign a_free  = !r_a_valid || b_free;
    assign o_ready = a_free;
    assign o_valid = r_b_valid;
    assign o_pix   = r_b_pix;
    assign o_pos   = r_b_pos;

    generate
        if (!WRAP) begin : g_full
            assign n_b_pos = ADDR_W'(r_a_pix.pixel_index);
        end else if (POW2) begin : g_mask
            assign n_b_pos = ADDR_W'(r_a_pix.pixel_index & IDX_W'(PIXELS - 1));
        end else begin : g_recip
            // q = (idx * M) >> (IDX_W + L) is exact for every 16-bit index
            localparam int SHIFT_L = $clog2(PIXELS);
            localparam int RSHIFT  = IDX_W + SHIFT_L;
            localparam longint unsigned RECIP =
                ((64'd1 << RSHIFT) + 64'(PIXELS) - 64'd1) / 64'(PIXELS);
            localparam int PROD_W = 2 * IDX_W + 1;

            logic [PROD_W-1:0] r_a_prod;
            logic [IDX_W-1:0]  quot;

            always_ff @(posedge i_clk) begin
                if (a_free && i_valid) begin
                    r_a_prod <= PROD_W'(i_pix.pixel_index) * PROD_W'(RECIP);
                end
            end

            assign quot    = IDX_W'(r_a_prod >> RSHIFT);
            assign n_b_pos = ADDR_W'(r_a_pix.pixel_index - IDX_W'(quot * IDX_W'(PIXELS)));
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= i_valid;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free && i_valid) begin
            r_a_pix <= i_pix;
        end
        if (b_free && r_a_valid) begin
            r_b_pix <= r_a_pix;
            r_b_pos <= n_b_pos;
        end
    end

endmodule

>>> hw/rtl/zbdc_mem.sv
// Depth and color stores: one read and one write port each, registered read data.
// A read of the entry written in the same cycle returns the new word. Depends on zbdc_pkg.
module zbdc_mem #(
    parameter int MEM_DEPTH  = 65536,
    parameter int ADDR_W     = 16,
    parameter int DEPTH_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_ren,
    input  logic [ADDR_W-1:0]            i_raddr,
    output logic [DEPTH_BITS-1:0]        o_rd_depth,
    output logic [zbdc_pkg::COLOR_W-1:0] o_rd_color,
    input  logic                         i_wen,
    input  logic [ADDR_W-1:0]            i_waddr,
    input  logic [DEPTH_BITS-1:0]        i_wr_depth,
    input  logic [zbdc_pkg::COLOR_W-1:0] i_wr_color
);
    import zbdc_pkg::*;

    logic [DEPTH_BITS-1:0] r_depth_mem [MEM_DEPTH];
    logic [COLOR_W-1:0]    r_color_mem [MEM_DEPTH];

    logic [DEPTH_BITS-1:0] r_q_depth;
    logic [COLOR_W-1:0]    r_q_color;
    logic [DEPTH_BITS-1:0] r_fwd_depth;
    logic [COLOR_W-1:0]    r_fwd_color;
    logic                  r_hit;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_depth_mem[i_waddr] <= i_wr_depth;
            r_color_mem[i_waddr] <= i_wr_color;
        end
        if (i_ren) begin
            r_q_depth   <= r_depth_mem[i_raddr];
            r_q_color   <= r_color_mem[i_raddr];
            r_fwd_depth <= i_wr_depth;
            r_fwd_color <= i_wr_color;
        end
    end

    // bypass flag: the array read above sees the old word on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ren) begin
            r_hit <= i_wen && (i_waddr == i_raddr);
        end
    end

    assign o_rd_depth = r_hit ? r_fwd_depth : r_q_depth;
    assign o_rd_color = r_hit ? r_fwd_color : r_q_color;

endmodule

>>> hw/rtl/zbdc_blend.sv
// One channel of the alpha blend: (stored*(255-a) + incoming*a + 127) / 255.
// Division by 255 uses the add-and-shift identity, exact below 65536. Depends on zbdc_pkg.
module zbdc_blend (
    input  logic [zbdc_pkg::CH_W-1:0] i_stored,
    input  logic [zbdc_pkg::CH_W-1:0] i_incoming,
    input  logic [zbdc_pkg::CH_W-1:0] i_alpha,
    output logic [zbdc_pkg::CH_W-1:0] o_value
);
    import zbdc_pkg::*;

    localparam int PROD_W = 2 * CH_W;
    localparam int SUM_W  = PROD_W + 1;

    logic [PROD_W-1:0] keep_part;
    logic [PROD_W-1:0] take_part;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  adj;

    assign keep_part = PROD_W'(i_stored) * PROD_W'(CH_MAX - i_alpha);
    assign take_part = PROD_W'(i_incoming) * PROD_W'(i_alpha);
    assign sum       = SUM_W'(keep_part) + SUM_W'(take_part) + SUM_W'(ROUND_BIAS);
    assign adj       = sum + SUM_W'(sum >> CH_W) + SUM_W'(1);
    assign o_value   = CH_W'(adj >> CH_W);

endmodule

>>> hw/rtl/zbuffer_depth_composite_core.sv
// Top level of the z-buffer depth compositing block: address stages, store
// read-modify-write stage and output register. Depends on zbdc_pkg, zbdc_addr,
// zbdc_mem and zbdc_blend.
//
//  channel | signals                                   | direction | word
//  --------+-------------------------------------------+-----------+------------------------
//  in      | i_in_valid / o_in_ready                   | input     | index, flag, depth, RGBA
//  out     | o_out_valid / i_out_ready                 | output    | index, depth, RGBA, won
//  cfg     | i_cfg_valid / o_cfg_ready                 | input     | alpha_mode bit
//
// One word per cycle sustained while the output is not stalled; a result passes through
// two address stages for the modulo, one store read-modify-write stage and one output
// register, the first of them loaded at the accepting edge.
// The store update happens in the read-modify-write stage; a word hitting the pixel
// written in the same cycle takes the new value from the store bypass.
// Reset clears the pipeline valids and alpha_mode; store contents stay undefined.
// An output stall backs up stage by stage; o_in_ready drops once all four are full.
module zbuffer_depth_composite_core #(
    parameter int PIXELS     = 65536,
    parameter int DEPTH_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [zbdc_pkg::IDX_W-1:0]      i_pixel_index,
    input  logic                            i_first_layer,
    input  logic [zbdc_pkg::IN_DEPTH_W-1:0] i_depth,
    input  logic [zbdc_pkg::CH_W-1:0]       i_red,
    input  logic [zbdc_pkg::CH_W-1:0]       i_green,
    input  logic [zbdc_pkg::CH_W-1:0]       i_blue,
    input  logic [zbdc_pkg::CH_W-1:0]       i_alpha,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [zbdc_pkg::IDX_W-1:0]      o_out_index,
    output logic [zbdc_pkg::IN_DEPTH_W-1:0] o_out_depth,
    output logic [zbdc_pkg::CH_W-1:0]       o_out_red,
    output logic [zbdc_pkg::CH_W-1:0]       o_out_green,
    output logic [zbdc_pkg::CH_W-1:0]       o_out_blue,
    output logic [zbdc_pkg::CH_W-1:0]       o_out_alpha,
    output logic                            o_won,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_alpha_mode
);
    import zbdc_pkg::*;

    localparam int MEM_DEPTH = (PIXELS < (1 << IDX_W)) ? PIXELS : (1 << IDX_W);
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    t_pix              in_pix;
    t_pix              b_pix;
    logic [ADDR_W-1:0] b_pos;
    logic              b_valid;
    logic              b_go;

    logic              r_alpha_mode;

    logic              r_c_valid;
    t_pix              r_c_pix;
    logic [ADDR_W-1:0] r_c_pos;
    logic              c_free;
    logic              c_go;

    logic [DEPTH_BITS-1:0] old_depth;
    logic [COLOR_W-1:0]    old_color;
    logic [DEPTH_BITS-1:0] in_z;
    logic [COLOR_W-1:0]    in_color;
    logic [COLOR_W-1:0]    mix_color;
    logic [COLOR_W-1:0]    new_color;
    logic [DEPTH_BITS-1:0] post_depth;
    logic [COLOR_W-1:0]    post_color;
    logic                  c_won;

    logic                  r_o_valid;
    logic [IDX_W-1:0]      r_o_index;
    logic [IN_DEPTH_W-1:0] r_o_depth;
    logic [COLOR_W-1:0]    r_o_color;
    logic                  r_o_won;
    logic                  o_free;

    assign in_pix = '{
        pixel_index: i_pixel_index,
        first_layer: i_first_layer,
        depth:       i_depth,
        red:         i_red,
        green:       i_green,
        blue:        i_blue,
        alpha:       i_alpha
    };

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_alpha_mode <= i_cfg_alpha_mode;
        end
    end

    // pipeline flow
    assign o_free = !r_o_valid || i_out_ready;
    assign c_free = !r_c_valid || o_free;
    assign c_go   = r_c_valid && o_free;
    assign b_go   = b_valid && c_free;

    zbdc_addr #(
        .PIXELS (PIXELS),
        .ADDR_W (ADDR_W)
    ) u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_pix   (in_pix),
        .o_valid (b_valid),
        .i_ready (c_free),
        .o_pix   (b_pix),
        .o_pos   (b_pos)
    );

    zbdc_mem #(
        .MEM_DEPTH  (MEM_DEPTH),
        .ADDR_W     (ADDR_W),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ren      (b_go),
        .i_raddr    (b_pos),
        .o_rd_depth (old_depth),
        .o_rd_color (old_color),
        .i_wen      (c_go && c_won),
        .i_waddr    (r_c_pos),
        .i_wr_depth (in_z),
        .i_wr_color (new_color)
    );

    // read-modify-write stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_free) begin
            r_c_valid <= b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_c_pix <= b_pix;
            r_c_pos <= b_pos;
        end
    end

    assign in_z     = DEPTH_BITS'(r_c_pix.depth);
    assign in_color = {r_c_pix.alpha, r_c_pix.blue, r_c_pix.green, r_c_pix.red};
    assign c_won    = r_c_pix.first_layer || (in_z <= old_depth);

    generate
        for (genvar ch = 0; ch < CH_NUM; ch++) begin : g_lane
            zbdc_blend u_blend (
                .i_stored   (old_color[ch*CH_W +: CH_W]),
                .i_incoming (in_color[ch*CH_W +: CH_W]),
                .i_alpha    (r_c_pix.alpha),
                .o_value    (mix_color[ch*CH_W +: CH_W])
            );
        end
    endgenerate

    always_comb begin
        if (!r_alpha_mode) begin
            // opaque write stores a zero alpha
            new_color = {CH_W'(0), in_color[CH_ALPHA*CH_W-1:0]};
        end else if (r_c_pix.first_layer) begin
            new_color = in_color;
        end else begin
            new_color = mix_color;
        end
    end

    assign post_depth = c_won ? in_z : old_depth;
    assign post_color = c_won ? new_color : old_color;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_free) begin
            r_o_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_go) begin
            r_o_index <= r_c_pix.pixel_index;
            r_o_depth <= IN_DEPTH_W'(post_depth);
            r_o_color <= r_alpha_mode ? post_color
                                      : {CH_W'(0), post_color[CH_ALPHA*CH_W-1:0]};
            r_o_won   <= c_won;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_index = r_o_index;
    assign o_out_depth = r_o_depth;
    assign o_out_red   = r_o_color[CH_RED*CH_W +: CH_W];
    assign o_out_green = r_o_color[CH_GREEN*CH_W +: CH_W];
    assign o_out_blue  = r_o_color[CH_BLUE*CH_W +: CH_W];
    assign o_out_alpha = r_o_color[CH_ALPHA*CH_W +: CH_W];
    assign o_won       = r_o_won;

endmodule

>>> hw/rtl/zbdc_checker.sv
// Port-level checks for zbuffer_depth_composite_core, attached by bind.
// Depends on zbdc_pkg and the top level's port list.
module zbdc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [zbdc_pkg::IDX_W-1:0]      o_out_index,
    input logic [zbdc_pkg::IN_DEPTH_W-1:0] o_out_depth,
    input logic [zbdc_pkg::CH_W-1:0]       o_out_red,
    input logic [zbdc_pkg::CH_W-1:0]       o_out_green,
    input logic [zbdc_pkg::CH_W-1:0]       o_out_blue,
    input logic [zbdc_pkg::CH_W-1:0]       o_out_alpha,
    input logic                            o_won
);
    import zbdc_pkg::*;

    // address stages, store stage and output register hold one word each
    localparam int CAPACITY = 4;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_inflight;
    logic [CNT_W-1:0] n_inflight;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    always_comb begin
        n_inflight = r_inflight;
        if (in_acc && !out_acc) begin
            n_inflight = r_inflight + CNT_W'(1);
        end else if (out_acc && !in_acc) begin
            n_inflight = r_inflight - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_index)
            && $stable(o_out_depth) && $stable(o_won) && $stable(o_out_red)
            && $stable(o_out_green) && $stable(o_out_blue) && $stable(o_out_alpha))
        else $error("stalled output word changed");

    a_no_invented_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_inflight != '0)
        else $error("output word without a pending input word");

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CNT_W'(CAPACITY))
        else $error("more words in flight than pipeline stages");

endmodule

bind zbuffer_depth_composite_core zbdc_checker u_checker (.*);
